[hdl/dsr_pkg.sv]
// shared types and constants of the diamond span rasterizer
package dsr_pkg;

    localparam int CANVAS_SIZE     = 1024;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int COORD_W         = 10;
    localparam int STRIDE_W        = 11;
    localparam int SPAN_W          = 11;
    localparam int BASE_W          = 20;
    localparam int OUTLINE_MAX_GAP = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_ROW_UP,
        ST_ROW_DN
    } dsr_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } row_ctrl_t;

endpackage

[hdl/dsr_div.sv]
// iterative restoring divider, one quotient bit per cycle
module dsr_div #(
    parameter int DVR_W = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dsr_pkg::SPAN_W-1:0] dividend,
    input  logic [DVR_W-1:0]           divisor,
    output logic                       done,
    output logic [dsr_pkg::SPAN_W-1:0] quot,
    output logic [DVR_W-1:0]           rem
);
    import dsr_pkg::*;

    localparam int CNT_W = $clog2(SPAN_W + 1);

    logic [SPAN_W-1:0] num_reg, num_next;
    logic [DVR_W-1:0]  rem_reg, rem_next;
    logic [DVR_W-1:0]  dvr_reg, dvr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DVR_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, num_reg[SPAN_W-1]};
    assign ge    = trial >= {1'b0, dvr_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvr_next  = dvr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            rem_next = '0;
            dvr_next = divisor;
            cnt_next = CNT_W'(SPAN_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[SPAN_W-2:0], ge};
            rem_next = ge ? DVR_W'(trial - {1'b0, dvr_reg}) : trial[DVR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
    end

    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

[hdl/dsr_row_unit.sv]
// row width stepper: keeps dw*(dh-h) as quotient and remainder by dh
module dsr_row_unit #(
    parameter int RW = 6
) (
    input  logic                       clk,
    input  dsr_pkg::row_ctrl_t         ctrl,
    input  logic [dsr_pkg::SPAN_W-1:0] dw,
    input  logic [RW-1:0]              dh,
    input  logic [dsr_pkg::SPAN_W-1:0] qa,
    input  logic [RW-1:0]              ra,
    output logic [dsr_pkg::SPAN_W-1:0] width
);
    import dsr_pkg::*;

    logic [SPAN_W-1:0] q_reg, q_next;
    logic [RW-1:0]     r_reg, r_next;
    logic [RW:0]       r_diff;
    logic              borrow;

    // one subtract and one conditional correction per row
    assign r_diff = {1'b0, r_reg} - {1'b0, ra};
    assign borrow = r_diff[RW];

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        if (ctrl.load)
        begin
            q_next = dw;
            r_next = '0;
        end
        else if (ctrl.step)
        begin
            q_next = q_reg - qa - SPAN_W'(borrow);
            r_next = borrow ? r_diff[RW-1:0] + dh : r_diff[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign width = q_reg;

endmodule

[hdl/diamond_span_rasterizer.sv]
// diamond span rasterizer top level: command sequencer, span formatting, result register
//
// One command (kind plus bounding box) is taken when start is high and busy is
// low. The block then stays busy: it checks the box and finds the center in
// ST_SETUP, runs the divider that splits the box width by the half height in
// ST_DIV, and then gives one result per drawn row, upper half from the center
// row up to top and lower half from the center row down to bottom (the center
// row comes twice). A command of height H rows therefore gives H + 1 row
// results; the tallest legal box has 63 rows. A rejected box gives one bad_box
// transaction. The next command can be taken as soon as busy is low again.
// Each result transaction shows on the result ports for exactly one cycle with
// valid high and must be captured then; last marks the final one of a command.
// The row width is stepped one row per cycle by a single subtract-and-correct
// unit, which is what sets the one-row-per-cycle rate. row_stride may be
// written through cfg_wr_en / cfg_wr_data while the block is idle.
module diamond_span_rasterizer #(
    parameter int MAX_ROWS = dsr_pkg::MAX_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic [dsr_pkg::COORD_W-1:0]       left,
    input  logic [dsr_pkg::COORD_W-1:0]       top,
    input  logic [dsr_pkg::COORD_W-1:0]       right,
    input  logic [dsr_pkg::COORD_W-1:0]       bottom,
    input  logic                              cfg_wr_en,
    input  logic [dsr_pkg::STRIDE_W-1:0]      cfg_wr_data,
    output logic                              valid,
    output logic [dsr_pkg::COORD_W-1:0]       row,
    output logic [dsr_pkg::BASE_W-1:0]        row_base,
    output logic signed [dsr_pkg::SPAN_W-1:0] first_start,
    output logic signed [dsr_pkg::SPAN_W-1:0] first_end,
    output logic                              second_valid,
    output logic signed [dsr_pkg::SPAN_W-1:0] second_start,
    output logic signed [dsr_pkg::SPAN_W-1:0] second_end,
    output logic                              bad_box,
    output logic                              last
);
    import dsr_pkg::*;

    // row count and half height fit in this many bits
    localparam int RW = $clog2(MAX_ROWS);
    localparam int PROD_W = COORD_W + STRIDE_W;
    localparam logic [COORD_W-1:0] HALF_MAX = COORD_W'(OUTLINE_MAX_GAP / 2);
    localparam logic [COORD_W:0] HGT_MAX = (COORD_W + 1)'(MAX_ROWS - 2);

    dsr_state_t state_reg, state_next;

    // command registers
    logic               kind_reg;
    logic [COORD_W-1:0] l_reg, t_reg, r_reg, b_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg, y_reg, y_next;
    logic [SPAN_W-1:0]  dw_reg;
    logic [RW-1:0]      dh_reg;
    logic [STRIDE_W-1:0] stride_reg;

    // box check and center
    logic               box_bad;
    logic [COORD_W-1:0] hgt, wid;
    logic [COORD_W-1:0] cx_calc, cy_calc;
    logic [SPAN_W-1:0]  dw_calc;
    logic [RW-1:0]      dh_calc;

    // sequencer outputs
    logic      accept, div_start, emit_row, emit_err, at_top, at_bot;
    row_ctrl_t row_ctrl;

    // arithmetic units
    logic              div_done;
    logic [SPAN_W-1:0] div_quot;
    logic [RW-1:0]     div_rem;
    logic [SPAN_W-1:0] row_w;

    // span formatting
    logic [COORD_W-1:0]      half;
    logic signed [SPAN_W:0]  s_ext, e_ext;
    logic                    split;
    logic [PROD_W-1:0]       prod;

    // result register
    logic                     valid_reg, valid_next;
    logic [COORD_W-1:0]       row_reg;
    logic [BASE_W-1:0]        base_reg;
    logic signed [SPAN_W-1:0] fs_reg, fe_reg, ss_reg, se_reg;
    logic                     sv_reg, bad_reg, last_reg;

    assign hgt     = b_reg - t_reg;
    assign wid     = r_reg - l_reg;
    assign box_bad = (r_reg < l_reg) || (b_reg < t_reg) || ({1'b0, hgt} > HGT_MAX);
    assign cx_calc = l_reg + (wid >> 1);
    assign cy_calc = t_reg + (hgt >> 1);
    assign dw_calc = {1'b0, wid} + SPAN_W'(1);
    assign dh_calc = RW'(hgt >> 1) + RW'(1);

    assign at_top = y_reg == t_reg;
    assign at_bot = y_reg == b_reg;
    assign busy   = state_reg != ST_IDLE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = box_bad ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_ROW_UP;
            end
            ST_ROW_UP:
            begin
                if (at_top)
                    state_next = ST_ROW_DN;
            end
            ST_ROW_DN:
            begin
                if (at_bot)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        accept        = 1'b0;
        div_start     = 1'b0;
        emit_row      = 1'b0;
        emit_err      = 1'b0;
        row_ctrl.load = 1'b0;
        row_ctrl.step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                accept = start;
            end
            ST_SETUP:
            begin
                div_start = !box_bad;
                emit_err  = box_bad;
            end
            ST_DIV:
            begin
                row_ctrl.load = div_done;
            end
            ST_ROW_UP:
            begin
                emit_row      = 1'b1;
                row_ctrl.load = at_top;
                row_ctrl.step = !at_top;
            end
            ST_ROW_DN:
            begin
                emit_row      = 1'b1;
                row_ctrl.step = !at_bot;
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase
    end

    // row walk: up from the center, then down from the center again
    always_comb
    begin
        y_next = y_reg;
        if (state_reg == ST_SETUP)
            y_next = cy_calc;
        else if (state_reg == ST_ROW_UP)
            y_next = at_top ? cy_reg : y_reg - COORD_W'(1);
        else if (state_reg == ST_ROW_DN)
            y_next = y_reg + COORD_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stride_reg <= STRIDE_W'(CANVAS_SIZE);
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_wr_en)
                stride_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            l_reg    <= left;
            t_reg    <= top;
            r_reg    <= right;
            b_reg    <= bottom;
        end
        if (state_reg == ST_SETUP)
        begin
            cx_reg <= cx_calc;
            cy_reg <= cy_calc;
            dw_reg <= dw_calc;
            dh_reg <= dh_calc;
        end
        y_reg <= y_next;
    end

    // dw split by dh into whole and fractional steps per row
    dsr_div #(
        .DVR_W (RW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dw_calc),
        .divisor  (dh_calc),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    dsr_row_unit #(
        .RW (RW)
    ) u_row (
        .clk   (clk),
        .ctrl  (row_ctrl),
        .dw    (dw_reg),
        .dh    (dh_reg),
        .qa    (div_quot),
        .ra    (div_rem),
        .width (row_w)
    );

    // span ends around the center column
    assign half  = row_w[SPAN_W-1:1];
    assign s_ext = $signed({2'b00, cx_reg}) - $signed({2'b00, half});
    assign e_ext = $signed({2'b00, cx_reg}) + $signed({2'b00, half});
    assign split = !kind_reg && (half > HALF_MAX);
    assign prod  = {{STRIDE_W{1'b0}}, y_reg} * {{COORD_W{1'b0}}, stride_reg};

    assign valid_next = emit_row || emit_err;

    always_ff @(posedge clk)
    begin
        if (emit_err)
        begin
            row_reg  <= '0;
            base_reg <= '0;
            fs_reg   <= '0;
            fe_reg   <= '0;
            sv_reg   <= 1'b0;
            ss_reg   <= '0;
            se_reg   <= '0;
            bad_reg  <= 1'b1;
            last_reg <= 1'b1;
        end
        else if (emit_row)
        begin
            row_reg  <= y_reg;
            base_reg <= prod[BASE_W-1:0];
            bad_reg  <= 1'b0;
            last_reg <= (state_reg == ST_ROW_DN) && at_bot;
            fs_reg   <= s_ext[SPAN_W-1:0];
            if (split)
            begin
                // outline: two 2-pixel edge spans
                fe_reg <= SPAN_W'(s_ext + (SPAN_W + 1)'(1));
                sv_reg <= 1'b1;
                ss_reg <= SPAN_W'(e_ext - (SPAN_W + 1)'(1));
                se_reg <= e_ext[SPAN_W-1:0];
            end
            else
            begin
                fe_reg <= e_ext[SPAN_W-1:0];
                sv_reg <= 1'b0;
                ss_reg <= '0;
                se_reg <= '0;
            end
        end
    end

    assign valid        = valid_reg;
    assign row          = row_reg;
    assign row_base     = base_reg;
    assign first_start  = fs_reg;
    assign first_end    = fe_reg;
    assign second_valid = sv_reg;
    assign second_start = ss_reg;
    assign second_end   = se_reg;
    assign bad_box      = bad_reg;
    assign last         = last_reg;

    // an error transaction is always the only one of its command
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && bad_box |-> last)
        else $error("bad_box transaction without last");

    // the command ends exactly with its final transaction
    a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid && last)
        else $error("busy dropped without a final transaction");

    // outline edge spans are two pixels wide
    a_edge_width: assert property (@(posedge clk) disable iff (!rst_n)
        valid && second_valid |->
            (second_end == second_start + 11'sd1) && (first_end == first_start + 11'sd1))
        else $error("outline edge span is not two pixels");

    // a single span never runs backwards
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !bad_box && !second_valid |-> first_start <= first_end)
        else $error("span start beyond span end");

endmodule
